>>> src/afcl_pkg.sv
package afcl_pkg;

    // Fixed field widths of the stream payloads
    localparam int FRAME_W     = 16;
    localparam int WDATA_W     = 64;
    localparam int SLOT_W      = 6;
    localparam int RDATA_W     = 64;
    localparam int IN_TDATA_W  = 80;   // frame_id + write_data
    localparam int OUT_TDATA_W = 72;   // hit + slot + read_data, padded to bytes

    // Age counters
    localparam int           AGE_W   = 16;
    localparam logic [15:0]  AGE_MAX = 16'hFFFF;

    // Operation codes (tuser)
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Configuration port
    localparam int          APB_ADDR_W    = 3;
    localparam int          APB_DATA_W    = 32;
    localparam int          CAP_W         = 7;
    localparam logic [2:0]  ADDR_CAPACITY = 3'd0;
    localparam logic [6:0]  CAP_RESET     = 7'd64;

    // Parameter defaults
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_TAG_W     = 16;
    localparam int DEF_PAYLOAD_W = 64;

    // Write enables for the three entry stores
    typedef struct packed {
        logic tag;
        logic age;
        logic pay;
    } t_store_we;

endpackage

>>> src/assoc_frame_cache_lru_unit.sv
// Fully associative frame cache with age-counter LRU replacement.
// Input stream (s_axis): tuser = op (0 put, 1 get); tdata = frame_id, write_data.
// Output stream (m_axis): one transfer per input transfer, tdata = hit, slot, read_data.
// A put walks the filled entries in slot order, one entry per cycle through the
// tag/age/payload memories (registered read, age written back behind the read).
// A tag match clears that entry's age, stores the payload and ends the walk;
// on a miss the entry is appended, or the first entry with the greatest age
// is replaced. A get walks only until the first match and changes nothing.
// Each walk goes through the single read port of the entry memories and covers
// at most the current fill, which is at most CAPACITY.
// The input is taken only while the block is idle; the result sits in an
// output register, so a stalled receiver holds one finished result and the
// next item may still be walked; it waits for the register only at the end.
// Reset empties the cache (fill count zero, no clearing pass) and sets capacity_in_use to
// 64. The user must write capacity_in_use (APB, address 0) only while the block is idle;
// the block does not enforce this. 0 acts as 1, values above CAPACITY act as CAPACITY.
module assoc_frame_cache_lru_unit #(
    parameter int CAPACITY      = afcl_pkg::DEF_CAPACITY,
    parameter int TAG_WIDTH     = afcl_pkg::DEF_TAG_W,
    parameter int PAYLOAD_WIDTH = afcl_pkg::DEF_PAYLOAD_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [afcl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [15:0] frame_id,
                                                                // [79:16] write_data
    input  logic                                s_axis_tuser,   // [0] op
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [afcl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [0] hit, [6:1] slot,
                                                                // [70:7] read_data, [71] zero
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afcl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [afcl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [afcl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > afcl_pkg::CAP_W) ? CNT_W : afcl_pkg::CAP_W) + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam int AGE_W = afcl_pkg::AGE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]               r_state, n_state;
    logic                     r_op;
    logic [TAG_WIDTH-1:0]     r_tag;
    logic [PAYLOAD_WIDTH-1:0] r_data;
    logic [CNT_W-1:0]         r_used, n_used;
    logic [afcl_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]         r_issue, n_issue;
    logic                     r_proc_valid, n_proc_valid;
    logic [IDX_W-1:0]         r_proc_idx;
    logic [AGE_W-1:0]         r_best_age, n_best_age;
    logic [IDX_W-1:0]         r_best_slot, n_best_slot;
    logic                     r_res_hit, n_res_hit;
    logic [IDX_W-1:0]         r_res_slot, n_res_slot;
    logic [PAYLOAD_WIDTH-1:0] r_res_data, n_res_data;
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic [afcl_pkg::SLOT_W-1:0]  r_out_slot;
    logic [afcl_pkg::RDATA_W-1:0] r_out_data;

    // memory ports
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic [TAG_WIDTH-1:0]     rd_tag;
    logic [AGE_W-1:0]         rd_age;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    afcl_pkg::t_store_we      we;
    logic [IDX_W-1:0]         wr_addr;
    logic [AGE_W-1:0]         wr_age;

    // decoded input fields
    logic [TAG_WIDTH+afcl_pkg::FRAME_W-1:0]     tag_ext;
    logic [PAYLOAD_WIDTH+afcl_pkg::WDATA_W-1:0] data_ext;
    logic [TAG_WIDTH-1:0]     in_tag;
    logic [PAYLOAD_WIDTH-1:0] in_data;

    logic                     in_fire;
    logic                     out_free;
    logic                     cfg_wr;
    logic                     match;
    logic                     last;
    logic [AGE_W-1:0]         aged;
    logic [CNT_W-1:0]         proc_cnt;
    logic [CMP_W-1:0]         used_cmp, cap_cmp;
    logic                     can_append;
    logic [IDX_W-1:0]         dest;
    logic [afcl_pkg::SLOT_W+IDX_W-1:0]            slot_ext;
    logic [afcl_pkg::RDATA_W+PAYLOAD_WIDTH-1:0]   rdata_ext;

    assign tag_ext  = {{TAG_WIDTH{1'b0}}, s_axis_tdata[afcl_pkg::FRAME_W-1:0]};
    assign in_tag   = tag_ext[TAG_WIDTH-1:0];
    assign data_ext = {{PAYLOAD_WIDTH{1'b0}},
                       s_axis_tdata[afcl_pkg::IN_TDATA_W-1:afcl_pkg::FRAME_W]};
    assign in_data  = data_ext[PAYLOAD_WIDTH-1:0];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // append allowed while fill is below the effective capacity
    assign used_cmp   = CMP_W'(r_used);
    assign cap_cmp    = CMP_W'(r_cap);
    assign can_append = (r_used != CAP_CNT) &&
                        ((used_cmp < cap_cmp) || (r_cap == '0 && r_used == '0));
    assign dest       = can_append ? r_used[IDX_W-1:0] : r_best_slot;

    assign match    = (rd_tag == r_tag);
    assign aged     = (rd_age == afcl_pkg::AGE_MAX) ? rd_age : rd_age + AGE_W'(1);
    assign proc_cnt = CNT_W'(r_proc_idx) + CNT_W'(1);
    assign last     = (proc_cnt == r_used);

    // read one entry ahead of the one being processed
    assign rd_en   = (r_state == ST_WALK) && (r_issue < r_used);
    assign rd_addr = r_issue[IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_issue      = r_issue;
        n_proc_valid = 1'b0;
        n_best_age   = r_best_age;
        n_best_slot  = r_best_slot;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        n_res_data   = r_res_data;
        we           = '0;
        wr_addr      = r_proc_idx;
        wr_age       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_issue     = '0;
                    n_best_age  = '0;
                    n_best_slot = '0;
                    n_res_hit   = 1'b0;
                    n_res_slot  = '0;
                    n_res_data  = '0;
                    if (r_used == '0) begin
                        n_state = (s_axis_tuser == afcl_pkg::OP_GET) ? ST_RESULT : ST_FINISH;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (rd_en) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                n_proc_valid = rd_en;
                if (r_proc_valid) begin
                    if (r_op == afcl_pkg::OP_GET) begin
                        if (match) begin
                            n_res_hit  = 1'b1;
                            n_res_slot = r_proc_idx;
                            n_res_data = rd_pay;
                            n_state    = ST_RESULT;
                        end else if (last) begin
                            n_state = ST_RESULT;
                        end
                    end else begin
                        we.age = 1'b1;
                        if (match) begin
                            wr_age     = '0;
                            we.pay     = 1'b1;
                            n_res_hit  = 1'b1;
                            n_res_slot = r_proc_idx;
                            n_state    = ST_RESULT;
                        end else begin
                            wr_age = aged;
                            if (aged > r_best_age) begin
                                n_best_age  = aged;
                                n_best_slot = r_proc_idx;
                            end
                            if (last) begin
                                n_state = ST_FINISH;
                            end
                        end
                    end
                end
            end
            ST_FINISH: begin
                we         = '{tag: 1'b1, age: 1'b1, pay: 1'b1};
                wr_addr    = dest;
                wr_age     = '0;
                n_res_slot = dest;
                if (can_append) begin
                    n_used = r_used + CNT_W'(1);
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    afcl_store #(
        .DEPTH     (CAPACITY),
        .TAG_W     (TAG_WIDTH),
        .PAYLOAD_W (PAYLOAD_WIDTH),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_tag  (rd_tag),
        .o_rd_age  (rd_age),
        .o_rd_pay  (rd_pay),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_tag  (r_tag),
        .i_wr_age  (wr_age),
        .i_wr_pay  (r_data)
    );

    assign slot_ext  = {{afcl_pkg::SLOT_W{1'b0}}, r_res_slot};
    assign rdata_ext = {{afcl_pkg::RDATA_W{1'b0}}, r_res_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_proc_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_proc_valid <= n_proc_valid;
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= s_axis_tuser;
            r_tag  <= in_tag;
            r_data <= in_data;
        end
        r_issue     <= n_issue;
        r_proc_idx  <= rd_addr;
        r_best_age  <= n_best_age;
        r_best_slot <= n_best_slot;
        r_res_hit   <= n_res_hit;
        r_res_slot  <= n_res_slot;
        r_res_data  <= n_res_data;
        if (r_state == ST_RESULT && out_free) begin
            r_out_hit  <= r_res_hit;
            r_out_slot <= slot_ext[afcl_pkg::SLOT_W-1:0];
            r_out_data <= rdata_ext[afcl_pkg::RDATA_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_data, r_out_slot, r_out_hit};

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == afcl_pkg::ADDR_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= afcl_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[afcl_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr == afcl_pkg::ADDR_CAPACITY) ? afcl_pkg::APB_DATA_W'(r_cap) : '0;

endmodule

>>> src/afcl_store.sv
module afcl_store #(
    parameter int DEPTH     = afcl_pkg::DEF_CAPACITY,
    parameter int TAG_W     = afcl_pkg::DEF_TAG_W,
    parameter int PAYLOAD_W = afcl_pkg::DEF_PAYLOAD_W,
    parameter int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_addr,
    output logic [TAG_W-1:0]              o_rd_tag,
    output logic [afcl_pkg::AGE_W-1:0]    o_rd_age,
    output logic [PAYLOAD_W-1:0]          o_rd_pay,
    input  afcl_pkg::t_store_we           i_we,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  logic [TAG_W-1:0]              i_wr_tag,
    input  logic [afcl_pkg::AGE_W-1:0]    i_wr_age,
    input  logic [PAYLOAD_W-1:0]          i_wr_pay
);

    logic [TAG_W-1:0]           tag_mem [DEPTH];
    logic [afcl_pkg::AGE_W-1:0] age_mem [DEPTH];
    logic [PAYLOAD_W-1:0]       pay_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.tag) begin
            tag_mem[i_wr_addr] <= i_wr_tag;
        end
        if (i_we.age) begin
            age_mem[i_wr_addr] <= i_wr_age;
        end
        if (i_we.pay) begin
            pay_mem[i_wr_addr] <= i_wr_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_tag <= tag_mem[i_rd_addr];
            o_rd_age <= age_mem[i_rd_addr];
            o_rd_pay <= pay_mem[i_rd_addr];
        end
    end

endmodule

>>> sim/assoc_frame_cache_lru_unit_tb.sv
module assoc_frame_cache_lru_unit_tb;

    localparam int          IN_TDATA_W    = afcl_pkg::IN_TDATA_W;
    localparam int          OUT_TDATA_W   = afcl_pkg::OUT_TDATA_W;
    localparam int          APB_ADDR_W    = afcl_pkg::APB_ADDR_W;
    localparam int          APB_DATA_W    = afcl_pkg::APB_DATA_W;
    localparam logic        OP_PUT        = afcl_pkg::OP_PUT;
    localparam logic        OP_GET        = afcl_pkg::OP_GET;
    localparam logic [15:0] AGE_MAX       = afcl_pkg::AGE_MAX;
    localparam logic [2:0]  ADDR_CAPACITY = afcl_pkg::ADDR_CAPACITY;
    localparam logic [6:0]  CAP_RESET     = afcl_pkg::CAP_RESET;

    localparam int NUM_SLOTS = afcl_pkg::DEF_CAPACITY;
    localparam int POOL_N    = 80;
    localparam int DRAIN     = 8;

    typedef struct packed {
        logic         hit;
        logic [5:0]   slot;
        logic [63:0]  rdata;
    } t_cache_reply;

    typedef enum logic [1:0] {ROW_CAP, ROW_TYPED, ROW_PREDICTED, ROW_REPEAT} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic         op;
        logic [15:0]  tag;
        logic [63:0]  data;    // payload, register value or repeat count
        t_cache_reply want;
    } t_stim_row;

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam t_stim_row DIRECTED_ROWS [27] = '{
        // capacity 0 behaves as a single entry
        '{ROW_CAP,       OP_PUT, 16'h0000, 64'h0,                     '0},
        '{ROW_TYPED,     OP_GET, 16'h0000, 64'h0,                     '{1'b0, 6'd0, 64'h0}},
        '{ROW_TYPED,     OP_PUT, 16'h0000, 64'h0,                     '{1'b0, 6'd0, 64'h0}},
        '{ROW_TYPED,     OP_GET, 16'h0000, 64'h0,                     '{1'b1, 6'd0, 64'h0}},
        '{ROW_TYPED,     OP_PUT, 16'hFFFF, ONES,                      '{1'b0, 6'd0, 64'h0}},
        '{ROW_TYPED,     OP_GET, 16'h0000, 64'h0,                     '{1'b0, 6'd0, 64'h0}},
        '{ROW_TYPED,     OP_GET, 16'hFFFF, 64'h0123_4567_89AB_CDEF,   '{1'b1, 6'd0, ONES}},
        // upper write bits are dropped: capacity 3
        '{ROW_CAP,       OP_PUT, 16'h0000, 64'hFFFF_FF83,             '0},
        '{ROW_TYPED,     OP_PUT, 16'h8000, 64'hA5A5_A5A5_A5A5_A5A5,   '{1'b0, 6'd1, 64'h0}},
        '{ROW_TYPED,     OP_PUT, 16'h0001, 64'h8000_0000_0000_0001,   '{1'b0, 6'd2, 64'h0}},
        '{ROW_TYPED,     OP_PUT, 16'h8000, 64'h5A5A_5A5A_5A5A_5A5A,   '{1'b1, 6'd1, 64'h0}},
        '{ROW_PREDICTED, OP_PUT, 16'h7FFE, 64'hC3C3_C3C3_C3C3_C3C3,   '0},
        '{ROW_PREDICTED, OP_GET, 16'h0001, 64'h0,                     '0},
        // hammer the last entry so the ones ahead of it keep aging
        '{ROW_REPEAT,    OP_PUT, 16'h0000, 64'd20,                    '0},
        '{ROW_PREDICTED, OP_PUT, 16'h3C3C, 64'h0F0F_0F0F_0F0F_0F0F,   '0},
        '{ROW_PREDICTED, OP_GET, 16'h8000, 64'h0,                     '0},
        '{ROW_CAP,       OP_PUT, 16'h0000, 64'd127,                   '0},
        '{ROW_PREDICTED, OP_PUT, 16'h4000, 64'h1111_2222_3333_4444,   '0},
        '{ROW_PREDICTED, OP_PUT, 16'h2AAA, 64'hAAAA_AAAA_AAAA_AAAA,   '0},
        '{ROW_PREDICTED, OP_PUT, 16'h5555, 64'h5555_5555_5555_5555,   '0},
        // capacity below the current fill
        '{ROW_CAP,       OP_PUT, 16'h0000, 64'd2,                     '0},
        '{ROW_PREDICTED, OP_PUT, 16'h1234, 64'hDEAD_BEEF_0000_FFFF,   '0},
        '{ROW_PREDICTED, OP_GET, 16'h1234, 64'h0,                     '0},
        '{ROW_PREDICTED, OP_GET, 16'hFFFF, 64'h0,                     '0},
        '{ROW_CAP,       OP_PUT, 16'h0000, 64'd64,                    '0},
        '{ROW_PREDICTED, OP_PUT, 16'h0F0F, ONES,                      '0},
        '{ROW_PREDICTED, OP_GET, 16'h3C3C, 64'h0,                     '0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata = '0;    // [15:0] frame_id, [79:16] write_data
    logic                       s_axis_tuser = 1'b0;  // [0] op
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;         // [0] hit, [6:1] slot, [70:7] read_data
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    // shadow copy of the cache
    logic [15:0]    shadow_tag     [NUM_SLOTS];
    logic [15:0]    shadow_age     [NUM_SLOTS];
    logic [63:0]    shadow_payload [NUM_SLOTS];
    int             shadow_fill = 0;
    logic [6:0]     shadow_cap = CAP_RESET;

    t_cache_reply   replies_due [$];
    logic [15:0]    tag_pool [POOL_N];
    int             mismatches = 0;
    int             send_idle = 0;
    int             recv_idle = 0;

    assoc_frame_cache_lru_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("assoc_frame_cache_lru_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t %s: got %h, want %h", $time, field, got, want);
        mismatches++;
    endtask

    // Search the shadow cache for one transfer; a put also ages and updates it.
    function automatic t_cache_reply cache_access(logic op, logic [15:0] tag,
                                                  logic [63:0] data);
        t_cache_reply reply;
        int           n;
        int           victim;
        logic [15:0]  victim_age;
        int           limit;
        reply = '0;
        n = shadow_fill;
        victim = 0;
        victim_age = '0;
        if (op == OP_GET) begin
            for (int i = 0; i < n; i++) begin
                if (shadow_tag[i] == tag) begin
                    reply.hit = 1'b1;
                    reply.slot = i[5:0];
                    reply.rdata = shadow_payload[i];
                    return reply;
                end
            end
            return reply;
        end
        for (int i = 0; i < n; i++) begin
            if (shadow_age[i] != AGE_MAX)
                shadow_age[i] = shadow_age[i] + 16'd1;
            if (shadow_tag[i] == tag) begin
                shadow_age[i] = '0;
                shadow_payload[i] = data;
                reply.hit = 1'b1;
                reply.slot = i[5:0];
                return reply;
            end
            if (shadow_age[i] > victim_age) begin
                victim_age = shadow_age[i];
                victim = i;
            end
        end
        limit = (shadow_cap == 0) ? 1 : ((shadow_cap > NUM_SLOTS) ? NUM_SLOTS : shadow_cap);
        if (n < limit) begin
            victim = n;
            shadow_fill = n + 1;
        end
        shadow_tag[victim] = tag;
        shadow_age[victim] = '0;
        shadow_payload[victim] = data;
        reply.slot = victim[5:0];
        return reply;
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_cache_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("result with none pending", m_axis_tdata[63:0], '0);
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                    report_mismatch("hit", m_axis_tdata[0], want.hit);
                if (m_axis_tdata[6:1] !== want.slot)
                    report_mismatch("slot", m_axis_tdata[6:1], want.slot);
                if (m_axis_tdata[70:7] !== want.rdata)
                    report_mismatch("read_data", m_axis_tdata[70:7], want.rdata);
                if (m_axis_tdata[71] !== 1'b0)
                    report_mismatch("tdata pad", m_axis_tdata[71], 1'b0);
            end
        end
    end

    // Present one transfer, with random idle cycles ahead of it.
    task automatic drive_item(logic op, logic [15:0] tag, logic [63:0] data,
                              bit typed, t_cache_reply want);
        t_cache_reply reply;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= IN_TDATA_W'({$urandom, $urandom, $urandom});
            s_axis_tuser <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {data, tag};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        reply = cache_access(op, tag, data);
        replies_due.push_back(typed ? want : reply);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Read transfers compare prdata with value.
    task automatic apb_access(bit wr, logic [APB_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wr ? value : $urandom;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== value)
            report_mismatch("capacity readback", prdata, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [31:0] value);
        wait_drained();
        apb_access(1'b1, ADDR_CAPACITY, value);
        shadow_cap = value[6:0];
        apb_access(1'b0, ADDR_CAPACITY, {25'd0, value[6:0]});
    endtask

    task automatic run_phase(int s_idle, int r_idle, logic [31:0] cap_first,
                             logic [31:0] cap_second, int count, int fresh);
        logic         op;
        logic [15:0]  tag;
        logic [63:0]  data;
        int           pick;
        set_capacity(cap_first);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int k = 0; k < count; k++) begin
            // sender holds off until the cache has gone idle
            if (k == count / 2)
                set_capacity(cap_second);
            op = ($urandom_range(9) < 4) ? OP_GET : OP_PUT;
            pick = $urandom_range(9);
            if (pick < fresh)
                tag = 16'($urandom);
            else if (pick < 7 || shadow_fill == 0)
                tag = tag_pool[$urandom_range(POOL_N - 1)];
            else
                tag = shadow_tag[$urandom_range(shadow_fill - 1)];
            data = {$urandom, $urandom};
            case ($urandom_range(15))
                0: data = '0;
                1: data = ONES;
                default: ;
            endcase
            drive_item(op, tag, data, 1'b0, '0);
        end
    endtask

    initial begin
        t_stim_row row;
        foreach (tag_pool[i])
            tag_pool[i] = 16'($urandom);
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, ADDR_CAPACITY, {25'd0, CAP_RESET});

        send_idle = 15;
        recv_idle = 84;
        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            case (row.kind)
                ROW_CAP: set_capacity(row.data[31:0]);
                ROW_REPEAT: begin
                    send_idle = 0;
                    recv_idle = 0;
                    for (int k = 0; k < row.data; k++)
                        drive_item(OP_PUT, shadow_tag[shadow_fill - 1], {$urandom, $urandom},
                                   1'b0, '0);
                    send_idle = 15;
                    recv_idle = 84;
                end
                default: drive_item(row.op, row.tag, row.data, row.kind == ROW_TYPED, row.want);
            endcase
        end

        run_phase(15, 84, 32'd1, $urandom_range(2, 12), 190, 1);
        run_phase(84, 15, 32'd64, 32'd127, 190, 2);
        run_phase(0, 0, $urandom_range(0, 127), $urandom_range(0, 127), 190, 1);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("assoc_frame_cache_lru_unit: match");
        end else begin
            $display("assoc_frame_cache_lru_unit: mismatch");
        end
        $finish;
    end

endmodule
